/* rtl/core/mbsp_pkg.sv */
// Package for the MIDI byte stream parser: beat payload types and status codes.
// No dependencies; imported by midi_byte_stream_parser_core.
`timescale 1ns / 1ps

package mbsp_pkg;

    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_TIME_CODE  = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_EOX        = 8'hF7;
    localparam logic [7:0] ST_REALTIME   = 8'hF8;
    localparam logic [5:0] ST_SINGLE_HI6 = 6'b111101;

    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS = 4'hA;
    localparam logic [3:0] HI_CTRL       = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND = 4'hE;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [7:0]  midi_byte;
        logic [12:0] arrival_time;
    } midi_in_t;

    typedef struct packed {
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [1:0]  message_length;
        logic [12:0] message_time;
    } midi_out_t;

endpackage

/* rtl/core/midi_byte_stream_parser_core.sv */
// MIDI byte stream parser top level: input register, running-status decode, result register.
// Depends on mbsp_pkg for the beat types and status codes.
`timescale 1ns / 1ps

// Takes one received MIDI byte per beat and returns a beat for every completed message.
// Real-time bytes (F8-FF) come out at once with their own arrival time and leave the parser
// state alone. Channel voice messages follow running status; F1/F3 and F2 are assembled,
// F4-F6 come out alone, and F7, SysEx data and orphan data bytes are dropped. A message
// carries the arrival time of its first byte since the last emitted message, where a zero
// time is replaced by the next byte's time. Unused data bytes read as zero. A byte can be
// accepted in every cycle while the result register is free or being taken by out_ready;
// a message beat reaches the output through the input register, the decode and the result
// register.
module midi_byte_stream_parser_core
    import mbsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  midi_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output midi_out_t out_data
);

    logic        in_valid_reg;
    midi_in_t    in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    midi_out_t   out_item_reg;
    logic [12:0] pending_time_reg;
    logic [12:0] pending_time_next;
    logic [7:0]  pend_b0_reg;
    logic [7:0]  pend_b0_next;
    logic [7:0]  pend_b1_reg;
    logic [7:0]  pend_b1_next;
    logic [7:0]  cur_status_reg;
    logic [7:0]  cur_status_next;
    logic        expect_third_reg;
    logic        expect_third_next;

    logic        fire;
    logic        emit;
    midi_out_t   result;
    logic [7:0]  b;
    logic [12:0] t;
    logic [12:0] mt;
    logic [3:0]  hi;

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;
    assign b        = in_item_reg.midi_byte;
    assign t        = in_item_reg.arrival_time;
    assign mt       = (pending_time_reg == '0) ? t : pending_time_reg;
    assign hi       = cur_status_reg[7:4];

    always_comb
    begin
        emit              = 1'b0;
        result            = '0;
        pending_time_next = mt;
        pend_b0_next      = pend_b0_reg;
        pend_b1_next      = pend_b1_reg;
        cur_status_next   = cur_status_reg;
        expect_third_next = expect_third_reg;

        if (b >= ST_REALTIME)
        begin
            // pass real-time beats through, hold all state
            emit                  = 1'b1;
            result.status_byte    = b;
            result.message_length = LEN_ONE;
            result.message_time   = t;
            pending_time_next     = pending_time_reg;
        end
        else if (b[7])
        begin
            cur_status_next   = b;
            expect_third_next = 1'b0;
            if (b[7:2] == ST_SINGLE_HI6 && b != ST_EOX)
            begin
                emit                  = 1'b1;
                result.status_byte    = b;
                result.message_length = LEN_ONE;
                result.message_time   = mt;
                pending_time_next     = '0;
            end
        end
        else if (expect_third_reg)
        begin
            expect_third_next     = 1'b0;
            emit                  = 1'b1;
            result.status_byte    = pend_b0_reg;
            result.first_data     = pend_b1_reg;
            result.second_data    = b;
            result.message_length = LEN_THREE;
            result.message_time   = mt;
            pending_time_next     = '0;
        end
        else if (cur_status_reg != '0)
        begin
            if ((hi inside {HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL, HI_PITCH_BEND})
                || cur_status_reg == ST_SONG_POS)
            begin
                expect_third_next = 1'b1;
                pend_b0_next      = cur_status_reg;
                pend_b1_next      = b;
                if (cur_status_reg == ST_SONG_POS)
                begin
                    cur_status_next = '0;
                end
            end
            else if ((hi inside {HI_PROGRAM, HI_CHAN_PRESS})
                || cur_status_reg == ST_TIME_CODE || cur_status_reg == ST_SONG_SEL)
            begin
                emit                  = 1'b1;
                result.status_byte    = cur_status_reg;
                result.first_data     = b;
                result.message_length = LEN_TWO;
                result.message_time   = mt;
                pending_time_next     = '0;
                if (cur_status_reg == ST_TIME_CODE || cur_status_reg == ST_SONG_SEL)
                begin
                    cur_status_next = '0;
                end
            end
            else
            begin
                // drop data under SysEx or single-byte status
                cur_status_next = '0;
            end
        end
    end

    assign out_valid_next = (fire && emit) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pending_time_reg <= '0;
            cur_status_reg   <= '0;
            expect_third_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                pending_time_reg <= pending_time_next;
                cur_status_reg   <= cur_status_next;
                expect_third_reg <= expect_third_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (fire)
        begin
            pend_b0_reg <= pend_b0_next;
            pend_b1_reg <= pend_b1_next;
        end
        if (fire && emit)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

/* tb/sv/midi_byte_stream_parser_core_test.sv */
// Self-checking testbench for midi_byte_stream_parser_core: directed and random byte streams
// against a running-status message predictor, with random idling on both beat channels.
// Depends on mbsp_pkg and midi_byte_stream_parser_core.
`timescale 1ns / 1ps

module midi_byte_stream_parser_core_test;
    import mbsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    midi_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    midi_out_t out_data;

    midi_out_t  expected_msgs[$];
    midi_out_t  oldest_msg;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;

    bit in_gaps_on = 1'b1;
    bit out_stalls_on = 1'b1;
    int out_hold_len = 0;
    bit hold_active = 1'b0;

    // parser state as seen by the predictor
    bit         msg_open = 1'b0;
    logic [12:0] msg_time = '0;
    logic [7:0] msg_first = '0;
    logic [7:0] msg_second = '0;
    logic [7:0] run_status = '0;
    bit         want_third = 1'b0;

    midi_byte_stream_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function void close_msg();
        msg_open = 1'b0;
        msg_time = '0;
        msg_first = '0;
        msg_second = '0;
    endfunction

    function void predict_byte(input midi_in_t beat);
        midi_out_t  msg;
        logic [7:0] b;
        logic [7:0] rs;
        b = beat.midi_byte;
        msg = '0;
        if (b >= ST_REALTIME) begin
            msg.status_byte = b;
            msg.message_length = LEN_ONE;
            msg.message_time = beat.arrival_time;
            expected_msgs.push_back(msg);
            return;
        end
        if (!msg_open) begin
            close_msg();
            msg_open = 1'b1;
        end
        if (msg_time == '0)
            msg_time = beat.arrival_time;
        msg.message_time = msg_time;
        rs = run_status;
        if (b[7]) begin
            run_status = b;
            want_third = 1'b0;
            if (b[7:2] == ST_SINGLE_HI6 && b != ST_EOX) begin
                msg.status_byte = b;
                msg.message_length = LEN_ONE;
                expected_msgs.push_back(msg);
                close_msg();
            end
            return;
        end
        if (want_third) begin
            want_third = 1'b0;
            msg.status_byte = msg_first;
            msg.first_data = msg_second;
            msg.second_data = b;
            msg.message_length = LEN_THREE;
            expected_msgs.push_back(msg);
            close_msg();
            return;
        end
        if (rs == '0)
            return;
        if (rs[7:4] inside {HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL, HI_PITCH_BEND}
            || rs == ST_SONG_POS)
        begin
            want_third = 1'b1;
            msg_first = rs;
            msg_second = b;
            if (rs == ST_SONG_POS)
                run_status = '0;
        end
        else if (rs[7:4] inside {HI_PROGRAM, HI_CHAN_PRESS}
                 || rs == ST_TIME_CODE || rs == ST_SONG_SEL)
        begin
            msg.status_byte = rs;
            msg.first_data = b;
            msg.message_length = LEN_TWO;
            expected_msgs.push_back(msg);
            close_msg();
            if (rs == ST_TIME_CODE || rs == ST_SONG_SEL)
                run_status = '0;
        end
        else begin
            run_status = '0;
        end
    endfunction

    function automatic logic [12:0] rand_time();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick < 2)
            return '0;
        if (pick == 2)
            return 13'h1FFF;
        return 13'($urandom_range(0, 8191));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [12:0] t);
        midi_in_t beat;
        beat.midi_byte = b;
        beat.arrival_time = t;
        if (in_gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(beat);
    endtask

    task automatic send_data(inout int sent);
        if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(ST_REALTIME, 8'hFF)), rand_time());
            sent++;
        end
        send_byte(8'($urandom_range(0, 127)), rand_time());
        sent++;
    endtask

    task automatic test_realtime();
        send_byte(8'h00, 13'd0);
        send_byte(8'h7F, 13'h1FFF);
        send_byte(ST_REALTIME, 13'd0);
        send_byte(8'hFF, 13'h1FFF);
    endtask

    task automatic test_channel_voice();
        send_byte({HI_NOTE_OFF, 4'h0}, 13'd5);
        send_byte(8'h3C, 13'd6);
        send_byte(8'h7F, 13'd7);
        send_byte(8'h7F, 13'd8);
        send_byte(8'h00, 13'd9);
        send_byte({HI_PROGRAM, 4'hF}, 13'd10);
        send_byte(8'h01, 13'd11);
        send_byte({HI_PITCH_BEND, 4'h5}, 13'd12);
        send_byte(8'hFA, 13'd13);
        send_byte(8'h7F, 13'd14);
        send_byte(8'h7F, 13'd15);
    endtask

    task automatic test_system_common();
        send_byte(ST_TIME_CODE, 13'd100);
        send_byte(8'h20, 13'd101);
        send_byte(8'h30, 13'd102);
        send_byte(ST_SONG_POS, 13'd0);
        send_byte(8'h01, 13'd77);
        send_byte(8'h02, 13'd78);
        send_byte(ST_SONG_SEL, 13'd200);
        send_byte(8'h7F, 13'd201);
        send_byte(8'hF4, 13'd300);
        send_byte(8'hF5, 13'd301);
        send_byte(8'hF6, 13'd302);
        send_byte(ST_EOX, 13'd303);
        send_byte(8'h11, 13'd304);
        send_byte(ST_SYSEX, 13'd305);
        send_byte(8'h12, 13'd306);
    endtask

    task automatic test_output_backpressure();
        in_valid <= 1'b0;
        out_hold_len = 150;
        while (!hold_active)
            @(posedge clk);
        in_gaps_on = 1'b0;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom_range(ST_REALTIME, 8'hFF)), rand_time());
        in_gaps_on = 1'b1;
    endtask

    task automatic test_random_stream(input int n_items);
        int         sent;
        int         kind;
        int         n_data;
        logic [7:0] voice_status;
        sent = 0;
        voice_status = '0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 15);
            if (kind <= 6) begin
                if (voice_status == '0 || $urandom_range(0, 2) == 0) begin
                    voice_status = {4'($urandom_range(HI_NOTE_OFF, HI_PITCH_BEND)),
                                    4'($urandom_range(0, 15))};
                    send_byte(voice_status, rand_time());
                    sent++;
                end
                n_data = (voice_status[7:4] inside {HI_PROGRAM, HI_CHAN_PRESS}) ? 1 : 2;
                for (int i = 0; i < n_data; i++)
                    send_data(sent);
            end
            else if (kind <= 9) begin
                voice_status = '0;
                case ($urandom_range(0, 2))
                    0: send_byte(ST_TIME_CODE, rand_time());
                    1: send_byte(ST_SONG_SEL, rand_time());
                    default:
                    begin
                        send_byte(ST_SONG_POS, rand_time());
                        send_data(sent);
                    end
                endcase
                sent++;
                send_data(sent);
            end
            else if (kind == 10) begin
                voice_status = '0;
                send_byte(8'($urandom_range(8'hF4, ST_EOX)), rand_time());
                sent++;
            end
            else if (kind == 11) begin
                voice_status = '0;
                send_byte(ST_SYSEX, rand_time());
                sent++;
                repeat ($urandom_range(0, 4))
                    send_data(sent);
                send_byte(ST_EOX, rand_time());
                sent++;
            end
            else if (kind == 12) begin
                send_byte(8'($urandom_range(ST_REALTIME, 8'hFF)), rand_time());
                sent++;
            end
            else if (kind == 13) begin
                voice_status = '0;
                send_byte(8'($urandom_range(0, 255)), rand_time());
                sent++;
            end
            else begin
                voice_status = '0;
                send_byte(8'($urandom_range(8'h80, ST_EOX)), rand_time());
                sent++;
                if ($urandom_range(0, 1) == 0)
                    send_data(sent);
            end
        end
    endtask

    initial
    begin
        forever
        begin
            if (out_hold_len != 0) begin
                out_ready <= 1'b0;
                hold_active = 1'b1;
                repeat (out_hold_len) @(posedge clk);
                out_hold_len = 0;
                hold_active = 1'b0;
            end
            else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    function void check_field(input string name, input logic [12:0] exp_val,
                              input logic [12:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_msgs.size() == 0) begin
                $error("message beat with nothing expected: %h", out_data);
                fail_count++;
            end
            else begin
                oldest_msg = expected_msgs.pop_front();
                check_field("status_byte", 13'(oldest_msg.status_byte),
                            13'(out_data.status_byte));
                check_field("first_data", 13'(oldest_msg.first_data),
                            13'(out_data.first_data));
                check_field("second_data", 13'(oldest_msg.second_data),
                            13'(out_data.second_data));
                check_field("message_length", 13'(oldest_msg.message_length),
                            13'(out_data.message_length));
                check_field("message_time", oldest_msg.message_time, out_data.message_time);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("midi_byte_stream_parser_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_realtime();
        test_channel_voice();
        test_system_common();
        test_output_backpressure();
        test_random_stream(290);
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        test_random_stream(90);
        in_valid <= 1'b0;
        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("midi_byte_stream_parser_core regression: pass");
        else
            $display("midi_byte_stream_parser_core regression: fail");
        $finish;
    end

endmodule
